>>> sv/zeckendorf_digit_encoder_defines.svh
// Assertion macros for the RTL files; zde_ctrl is the one that includes them.
`ifndef ZECKENDORF_DIGIT_ENCODER_DEFINES_SVH
`define ZECKENDORF_DIGIT_ENCODER_DEFINES_SVH

`ifndef SYNTHESIS
// Checked on every rising edge of clk_i, switched off while rst_ni is low.
`define ZDE_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("zde: assertion failed");
// Checked on every rising edge of clk_i, reset included.
`define ZDE_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk_i) prop) \
    else $error("zde: assertion failed");
`else
`define ZDE_ASSERT(label, prop)
`define ZDE_ASSERT_ALWAYS(label, prop)
`endif

`endif

>>> sv/zde_pkg.sv
package zde_pkg;

  localparam int KEY_BITS     = 60;
  localparam int WEIGHT_COUNT = 92;
  localparam int WEIGHT_BITS  = 64;
  localparam int LOW_BITS     = 64;
  localparam int HIGH_BITS    = 23;
  localparam int DIGIT_BITS   = LOW_BITS + HIGH_BITS;
  localparam int INDEX_BITS   = $clog2(WEIGHT_COUNT);
  localparam int COUNT_BITS   = 7;

  localparam logic [INDEX_BITS-1:0] LAST_INDEX = INDEX_BITS'(WEIGHT_COUNT - 1);

  typedef logic [WEIGHT_COUNT-1:0][WEIGHT_BITS-1:0] weight_table_t;

  // Fibonacci weights F(j+2) for j = 0 up to the last index.
  function automatic weight_table_t fib_table();
    weight_table_t t;
    t    = '0;
    t[0] = WEIGHT_BITS'(1);
    t[1] = WEIGHT_BITS'(2);
    for (int j = 2; j < WEIGHT_COUNT; j++) begin
      t[j] = t[j-1] + t[j-2];
    end
    return t;
  endfunction

  localparam weight_table_t WEIGHTS = fib_table();

  // Control that the sequencer hands to the row of digit cells.
  typedef struct packed {
    logic shift;
    logic digit;
  } chain_ctrl_t;

endpackage

>>> sv/zde_cell.sv
// One digit position of the shift chain; it takes the digit at its input on every shift.
module zde_cell (
  input  logic clk_i,
  input  logic shift_i,
  input  logic digit_i,
  output logic digit_o
);

  logic digit_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      digit_q <= digit_i;
    end
  end

  assign digit_o = digit_q;

endmodule

>>> sv/zde_ctrl.sv
`include "zeckendorf_digit_encoder_defines.svh"

// Greedy digit sequencer: one Fibonacci weight per cycle, largest first.
module zde_ctrl import zde_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic [KEY_BITS-1:0]   number_k_i,
  output chain_ctrl_t           chain_o,
  output logic                  done_o,
  output logic [COUNT_BITS-1:0] digit_count_o
);

  typedef enum logic {
    IDLE,
    RUN
  } state_e;

  state_e                state_q, state_d;
  logic [INDEX_BITS-1:0] idx_q, idx_d;
  logic [KEY_BITS-1:0]   rest_q, rest_d;
  logic [COUNT_BITS-1:0] count_q, count_d;
  logic                  done_q, done_d;
  logic [WEIGHT_BITS-1:0] weight;
  logic                  take;

  assign weight = WEIGHTS[idx_q];
  assign take   = (state_q == RUN) && (WEIGHT_BITS'(rest_q) >= weight);

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    rest_d  = rest_q;
    count_d = count_q;
    done_d  = 1'b0;
    unique case (state_q)
      IDLE: begin
        if (start) begin
          state_d = RUN;
          idx_d   = LAST_INDEX;
          rest_d  = number_k_i;
          count_d = '0;
        end
      end
      RUN: begin
        if (take) begin
          rest_d = rest_q - KEY_BITS'(weight);
          if (count_q == '0) begin
            count_d = COUNT_BITS'(idx_q) + COUNT_BITS'(1);
          end
        end
        if (idx_q == '0) begin
          state_d = IDLE;
          done_d  = 1'b1;
        end else begin
          idx_d = idx_q - INDEX_BITS'(1);
        end
      end
      default: state_d = IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= IDLE;
      done_q  <= 1'b0;
      idx_q   <= '0;
      rest_q  <= '0;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      idx_q   <= idx_d;
      rest_q  <= rest_d;
      count_q <= count_d;
    end
  end

  assign busy          = (state_q == RUN);
  assign chain_o.shift = (state_q == RUN);
  assign chain_o.digit = take;
  assign done_o        = done_q;
  assign digit_count_o = count_q;

  `ZDE_ASSERT(a_start_loads, (start && !busy) |=> (busy && idx_q == LAST_INDEX))
  `ZDE_ASSERT(a_last_weight_done, (busy && idx_q == '0) |=> (done_q && !busy))
  `ZDE_ASSERT(a_rest_consumed, done_q |-> (rest_q == '0))
  `ZDE_ASSERT_ALWAYS(a_done_not_busy, done_q |-> !busy)

endmodule

>>> sv/zeckendorf_digit_encoder.sv
// Zeckendorf digit encoder. A request is taken at a rising clock edge where start
// is high and busy is low; number_k_i is the number k to encode and is sampled at
// that edge only. The block then holds busy high while it tests one Fibonacci
// weight per cycle from F(93) down to F(2) through a single compare-and-subtract
// unit; that weight loop sets the rate. In the cycle in which busy falls, done_o is
// high for exactly one cycle with digits_low_o, digits_high_o and digit_count_o
// valid. The receiver cannot stall: the result is there for that one cycle only
// and must be captured then. A new request may be issued in the done cycle, but
// not while busy, so a request is only taken once the previous one is done. A
// value of zero gives all-zero digits and a digit count of zero.
module zeckendorf_digit_encoder import zde_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic [KEY_BITS-1:0]   number_k_i,
  output logic                  done_o,
  output logic [LOW_BITS-1:0]   digits_low_o,
  output logic [HIGH_BITS-1:0]  digits_high_o,
  output logic [COUNT_BITS-1:0] digit_count_o
);

  chain_ctrl_t           chain_ctrl;
  logic [DIGIT_BITS-1:0] chain;

  // The sequencer decides each digit, leading digit first, and owns the count.
  zde_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .number_k_i    (number_k_i),
    .chain_o       (chain_ctrl),
    .done_o        (done_o),
    .digit_count_o (digit_count_o)
  );

  // Digits enter at cell zero and move one cell up per cycle while busy, so after
  // the last weight the leading digit sits at its own position. Digits above the top
  // cell fall off the end; they can only appear for keys wider than the port.
  for (genvar i = 0; i < DIGIT_BITS; i++) begin : g_cell
    logic cell_in;
    if (i == 0) begin : g_head
      assign cell_in = chain_ctrl.digit;
    end else begin : g_body
      assign cell_in = chain[i-1];
    end
    zde_cell u_cell (
      .clk_i   (clk_i),
      .shift_i (chain_ctrl.shift),
      .digit_i (cell_in),
      .digit_o (chain[i])
    );
  end

  // The cells hold still while idle, so the digits stay valid through the done cycle.
  assign digits_low_o  = chain[LOW_BITS-1:0];
  assign digits_high_o = chain[DIGIT_BITS-1:LOW_BITS];

endmodule
